[src/bss_pkg.sv]
// shared types and constants of the buffer size snapper
`default_nettype none
package bss_pkg;

	localparam int SIZE_BITS = 20;
	localparam int WIDE_BITS = SIZE_BITS + 1;
	localparam int CELLS     = WIDE_BITS;
	localparam int LATENCY   = CELLS + 2;

	typedef enum logic [1:0] {
		MODE_PREF,
		MODE_FIXED,
		MODE_POW,
		MODE_STEP
	} mode_t;

	typedef enum logic [1:0] {
		REG_MIN,
		REG_MAX,
		REG_PREF,
		REG_STEP
	} reg_idx_t;

	typedef struct packed {
		logic [SIZE_BITS-1:0] lo;
		logic [SIZE_BITS-1:0] hi;
		logic [SIZE_BITS-1:0] floor_pow;
		logic [WIDE_BITS-1:0] step;
	} limits_t;

	typedef struct packed {
		logic                 valid;
		mode_t                mode;
		logic [SIZE_BITS-1:0] req;
		logic [WIDE_BITS-1:0] num;
		logic [WIDE_BITS-1:0] sh;
		logic [SIZE_BITS-1:0] rem;
		logic [WIDE_BITS-1:0] pow;
		logic [WIDE_BITS-1:0] best;
		logic [WIDE_BITS-1:0] gap;
		logic                 found;
	} cell_t;

endpackage
`default_nettype wire

[src/bss_front.sv]
// request decode and step numerator, feeds the head of the cell row
`default_nettype none
module bss_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [bss_pkg::WIDE_BITS-1:0] requested_size,
	input  wire bss_pkg::limits_t              limits,
	output bss_pkg::cell_t                     head
);
	import bss_pkg::*;

	cell_t                cell_d;
	cell_t                cell_s1;
	logic                 req_pos;
	logic                 step_pos;
	logic                 step_pow;
	logic [WIDE_BITS:0]   num_w;
	logic                 num_pos;

	always_comb begin
		req_pos  = !requested_size[WIDE_BITS-1] && (requested_size != '0);
		step_pos = !limits.step[WIDE_BITS-1] && (limits.step != '0);
		step_pow = &limits.step;
		num_w    = {2'b00, requested_size[SIZE_BITS-1:0]} - {2'b00, limits.lo}
		         + {3'b000, limits.step[SIZE_BITS-1:1]};
		num_pos  = !num_w[WIDE_BITS] && (num_w != '0);
	end

	always_comb begin
		cell_d       = '0;
		cell_d.valid = start;
		cell_d.req   = requested_size[SIZE_BITS-1:0];
		cell_d.num   = num_pos ? num_w[WIDE_BITS-1:0] : '0;
		cell_d.sh    = cell_d.num;
		cell_d.pow   = {{(WIDE_BITS-1){1'b0}}, 1'b1};
		if (!req_pos) begin
			cell_d.mode = MODE_PREF;
		end else if (limits.lo != '0 && limits.hi != '0 && limits.lo == limits.hi) begin
			cell_d.mode = MODE_FIXED;
		end else if (step_pow) begin
			cell_d.mode = MODE_POW;
		end else if (step_pos) begin
			cell_d.mode = MODE_STEP;
		end else begin
			cell_d.mode = MODE_PREF;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_s1 <= '0;
		end else begin
			cell_s1 <= cell_d;
		end
	end

	assign head = cell_s1;

endmodule
`default_nettype wire

[src/bss_cell.sv]
// one cell: a restoring divider bit and one power of two candidate
`default_nettype none
module bss_cell (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire bss_pkg::limits_t limits,
	input  wire bss_pkg::cell_t   prev,
	output bss_pkg::cell_t        next
);
	import bss_pkg::*;

	cell_t                cell_d;
	cell_t                cell_q;
	logic [WIDE_BITS-1:0] trial;
	logic [WIDE_BITS-1:0] gran;
	logic [WIDE_BITS-1:0] trial_sub;
	logic [WIDE_BITS:0]   diff;
	logic [WIDE_BITS:0]   mag;
	logic [WIDE_BITS-1:0] gap;
	logic                 ge_floor;
	logic                 le_hi;

	always_comb begin
		gran      = {1'b0, limits.step[SIZE_BITS-1:0]};
		trial     = {prev.rem, prev.sh[WIDE_BITS-1]};
		trial_sub = trial - gran;
		diff      = {1'b0, prev.pow} - {2'b00, prev.req};
		mag       = diff[WIDE_BITS] ? (~diff + 1'b1) : diff;
		gap       = mag[WIDE_BITS-1:0];
		ge_floor  = prev.pow >= {1'b0, limits.floor_pow};
		le_hi     = prev.pow <= {1'b0, limits.hi};
	end

	always_comb begin
		cell_d     = prev;
		cell_d.sh  = {prev.sh[WIDE_BITS-2:0], 1'b0};
		cell_d.rem = (trial >= gran) ? trial_sub[SIZE_BITS-1:0] : trial[SIZE_BITS-1:0];
		cell_d.pow = {prev.pow[WIDE_BITS-2:0], 1'b0};
		if (ge_floor && !prev.found) begin
			cell_d.best  = prev.pow;
			cell_d.gap   = gap;
			cell_d.found = 1'b1;
		end else if (ge_floor && le_hi && gap < prev.gap) begin
			cell_d.best = prev.pow;
			cell_d.gap  = gap;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_q <= '0;
		end else begin
			cell_q <= cell_d;
		end
	end

	assign next = cell_q;

`ifndef SYNTHESIS
	a_rem_below_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cell_q.valid && cell_q.mode == MODE_STEP) |-> (cell_q.rem < gran))
		else $error("step remainder not below step size");

	a_found_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(prev.valid && prev.found) |=> cell_q.found)
		else $error("power candidate lost along the row");
`endif

endmodule
`default_nettype wire

[src/bss_back.sv]
// result select, step clamp and result register
`default_nettype none
module bss_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire bss_pkg::limits_t              limits,
	input  wire logic [bss_pkg::SIZE_BITS-1:0] preferred,
	input  wire bss_pkg::cell_t                tail,
	output logic                               done,
	output logic [bss_pkg::WIDE_BITS-1:0]      chosen_size
);
	import bss_pkg::*;

	logic [WIDE_BITS:0]   v_w;
	logic [WIDE_BITS-1:0] v_step;
	logic [WIDE_BITS-1:0] result;
	logic                 done_q;
	logic [WIDE_BITS-1:0] chosen_q;

	always_comb begin
		v_w    = {2'b00, limits.lo} + {1'b0, tail.num} - {2'b00, tail.rem};
		v_step = v_w[WIDE_BITS-1:0];
		if (v_step > {1'b0, limits.hi}) begin
			v_step = {1'b0, limits.hi};
		end
		unique case (tail.mode)
			MODE_PREF:  result = {1'b0, preferred};
			MODE_FIXED: result = {1'b0, limits.lo};
			MODE_POW:   result = tail.best;
			MODE_STEP:  result = v_step;
			default:    result = {1'b0, preferred};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= tail.valid;
		end
	end

	always_ff @(posedge clk) begin
		chosen_q <= result;
	end

	assign done        = done_q;
	assign chosen_size = chosen_q;

`ifndef SYNTHESIS
	a_pow_found: assert property (@(posedge clk) disable iff (!arst_n)
		(tail.valid && tail.mode == MODE_POW) |-> tail.found)
		else $error("power search ended without a candidate");
`endif

endmodule
`default_nettype wire

[src/buffer_size_snapper.sv]
// buffer size snapper: a request enters every cycle and walks a row of 21 cells
// done rises after the item passes the front register, the cell row and the done register
// throughput: one item per cycle, set by the row of divider and power cells
// busy stays low; results cannot be held off and leave on done for one cycle
// reset: arst_n clears all limits to zero and empties the row asynchronously
`default_nettype none
module buffer_size_snapper (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [bss_pkg::WIDE_BITS-1:0] requested_size,
	output logic                               done,
	output logic [bss_pkg::WIDE_BITS-1:0]      chosen_size,
	input  wire logic                          wr_en,
	input  wire logic [1:0]                    wr_index,
	input  wire logic [bss_pkg::WIDE_BITS-1:0] wr_data
);
	import bss_pkg::*;

	logic [SIZE_BITS-1:0] min_q;
	logic [SIZE_BITS-1:0] max_q;
	logic [SIZE_BITS-1:0] pref_q;
	logic [WIDE_BITS-1:0] step_q;
	limits_t              limits;
	cell_t                chain [0:CELLS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q  <= '0;
			max_q  <= '0;
			pref_q <= '0;
			step_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_MIN:  min_q  <= wr_data[SIZE_BITS-1:0];
				REG_MAX:  max_q  <= wr_data[SIZE_BITS-1:0];
				REG_PREF: pref_q <= wr_data[SIZE_BITS-1:0];
				REG_STEP: step_q <= wr_data;
				default:  ;
			endcase
		end
	end

	always_comb begin
		limits.lo        = min_q;
		limits.hi        = max_q;
		limits.floor_pow = (min_q != '0) ? min_q : {{(SIZE_BITS-1){1'b0}}, 1'b1};
		limits.step      = step_q;
	end

	assign busy = 1'b0;

	bss_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.requested_size (requested_size),
		.limits         (limits),
		.head           (chain[0])
	);

	for (genvar g = 0; g < CELLS; g++) begin : g_cell
		bss_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.limits (limits),
			.prev   (chain[g]),
			.next   (chain[g+1])
		);
	end

	bss_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.limits      (limits),
		.preferred   (pref_q),
		.tail        (chain[CELLS]),
		.done        (done),
		.chosen_size (chosen_size)
	);

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LATENCY))
		else $error("result without a matching item");
`endif

endmodule
`default_nettype wire

[test/tb.sv]
// testbench for buffer_size_snapper: directed table and random requests against a predictor
`timescale 1ns / 1ps
module tb;
	import bss_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES      = 12;
	localparam int PHASE_ITEMS = 118;
	localparam logic [WIDE_BITS-1:0] POW_MODE = '1;

	typedef struct packed {
		logic [SIZE_BITS-1:0] lo;
		logic [SIZE_BITS-1:0] hi;
		logic [SIZE_BITS-1:0] pref;
		logic [WIDE_BITS-1:0] step;
		logic [WIDE_BITS-1:0] req;
		logic                 typed;
		logic [WIDE_BITS-1:0] size;
	} row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [WIDE_BITS-1:0] requested_size;
	logic                 done;
	logic [WIDE_BITS-1:0] chosen_size;
	logic                 wr_en;
	logic [1:0]           wr_index;
	logic [WIDE_BITS-1:0] wr_data;

	logic                 fix_valid;
	logic [WIDE_BITS-1:0] fix_size;

	logic [SIZE_BITS-1:0] lim_min = '0;
	logic [SIZE_BITS-1:0] lim_max = '0;
	logic [SIZE_BITS-1:0] lim_pref = '0;
	logic [WIDE_BITS-1:0] lim_step = '0;

	logic [WIDE_BITS-1:0] chosen_q [$];
	int                   mismatches = 0;
	int                   cycle_count = 0;
	int                   idle_pct;
	int                   idle_pcts [3] = '{0, 68, 9};

	row_t rows [0:19] = '{
		'{20'd0, 20'd0, 20'd0, 21'd0, 21'd100, 1'b1, 21'd0},
		'{20'd64, 20'd4096, 20'd256, 21'd0, 21'd0, 1'b1, 21'd256},
		'{20'd64, 20'd4096, 20'd256, 21'd0, 21'h100000, 1'b1, 21'd256},
		'{20'd64, 20'd4096, 20'd256, 21'd0, 21'h0FFFFF, 1'b1, 21'd256},
		'{20'd512, 20'd512, 20'd256, POW_MODE, 21'd1000, 1'b1, 21'd512},
		'{20'd64, 20'd4096, 20'd256, POW_MODE, 21'd100, 1'b0, 21'd0},
		'{20'd64, 20'd4096, 20'd256, POW_MODE, 21'd96, 1'b0, 21'd0},
		'{20'd64, 20'd4096, 20'd256, POW_MODE, 21'h0FFFFF, 1'b1, 21'd4096},
		'{20'd64, 20'd4096, 20'd256, POW_MODE, 21'd1, 1'b1, 21'd64},
		'{20'hFFFFF, 20'd0, 20'd7, POW_MODE, 21'd5, 1'b1, 21'h100000},
		'{20'd0, 20'd0, 20'd7, POW_MODE, 21'd1000, 1'b1, 21'd1},
		'{20'd100, 20'd1000, 20'd300, 21'd64, 21'd150, 1'b0, 21'd0},
		'{20'd100, 20'd1000, 20'd300, 21'd64, 21'd1, 1'b1, 21'd100},
		'{20'd100, 20'd1000, 20'd300, 21'd64, 21'h0FFFFF, 1'b1, 21'd1000},
		'{20'd100, 20'd0, 20'd300, 21'd64, 21'd500, 1'b1, 21'd0},
		'{20'd500, 20'd100, 20'd300, 21'd10, 21'd700, 1'b1, 21'd100},
		'{20'd0, 20'hFFFFF, 20'd300, 21'h0FFFFF, 21'h0FFFFF, 1'b0, 21'd0},
		'{20'd0, 20'hFFFFF, 20'hFFFFF, 21'h1FFFFE, 21'd50, 1'b1, 21'h0FFFFF},
		'{20'd0, 20'hFFFFF, 20'hFFFFF, 21'h100000, 21'd50, 1'b1, 21'h0FFFFF},
		'{20'd0, 20'hFFFFF, 20'hFFFFF, 21'd1, 21'd12345, 1'b0, 21'd0}
	};

	buffer_size_snapper dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.requested_size (requested_size),
		.done           (done),
		.chosen_size    (chosen_size),
		.wr_en          (wr_en),
		.wr_index       (wr_index),
		.wr_data        (wr_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [WIDE_BITS-1:0] snap_size(input logic [WIDE_BITS-1:0] req_raw);
		longint r, lo, hi, g, first, best, cand, dc, db, num, cnt, v;
		r  = longint'($signed(req_raw));
		lo = longint'(lim_min);
		hi = longint'(lim_max);
		g  = longint'($signed(lim_step));
		if (r <= 0)
			return {1'b0, lim_pref};
		if (lo > 0 && hi > 0 && lo == hi)
			return lo[WIDE_BITS-1:0];
		if (g == -1) begin
			first = 1;
			while (first < ((lo > 0) ? lo : 1))
				first = first * 2;
			best = first;
			for (cand = first; cand <= hi; cand = cand * 2) begin
				dc = (cand > r) ? cand - r : r - cand;
				db = (best > r) ? best - r : r - best;
				if (dc < db)
					best = cand;
			end
			return best[WIDE_BITS-1:0];
		end
		if (g > 0) begin
			num = r - lo + g / 2;
			cnt = (num > 0) ? num / g : 0;
			v   = lo + cnt * g;
			if (v < lo)
				v = lo;
			if (v > hi)
				v = hi;
			return v[WIDE_BITS-1:0];
		end
		return {1'b0, lim_pref};
	endfunction

	task automatic report_mismatch(input string what, input logic [WIDE_BITS-1:0] got,
			input logic [WIDE_BITS-1:0] want);
		$display("mismatch: %s chosen_size %0d expected %0d at %0t ns", what, got, want, $realtime);
		mismatches++;
	endtask

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		logic [WIDE_BITS-1:0] want;
		if (arst_n) begin
			if (done) begin
				if (chosen_q.size() == 0) begin
					report_mismatch("unexpected result", chosen_size, '0);
				end else begin
					want = chosen_q.pop_front();
					if (chosen_size !== want)
						report_mismatch("wrong size", chosen_size, want);
				end
			end
			if (start && !busy)
				chosen_q = {chosen_q, (fix_valid ? fix_size : snap_size(requested_size))};
			if (wr_en) begin
				case (reg_idx_t'(wr_index))
					REG_MIN:  lim_min  = wr_data[SIZE_BITS-1:0];
					REG_MAX:  lim_max  = wr_data[SIZE_BITS-1:0];
					REG_PREF: lim_pref = wr_data[SIZE_BITS-1:0];
					REG_STEP: lim_step = wr_data;
					default: ;
				endcase
			end
		end
	end

	task automatic write_reg(input reg_idx_t idx, input logic [WIDE_BITS-1:0] data);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(negedge clk);
	endtask

	task automatic set_limits(input logic [WIDE_BITS-1:0] lo, input logic [WIDE_BITS-1:0] hi,
			input logic [WIDE_BITS-1:0] pref, input logic [WIDE_BITS-1:0] step);
		write_reg(REG_MIN, lo);
		write_reg(REG_MAX, hi);
		write_reg(REG_PREF, pref);
		write_reg(REG_STEP, step);
		wr_en <= 1'b0;
	endtask

	task automatic drain;
		start <= 1'b0;
		do
			@(negedge clk);
		while (chosen_q.size() != 0);
	endtask

	task automatic send_item(input logic [WIDE_BITS-1:0] req, input logic typed,
			input logic [WIDE_BITS-1:0] size);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start          <= 1'b1;
		requested_size <= req;
		fix_valid      <= typed;
		fix_size       <= size;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [SIZE_BITS-1:0] rand_size();
		case ($urandom_range(3))
			0: return SIZE_BITS'($urandom);
			1: return SIZE_BITS'($urandom_range(0, 4096));
			2: return SIZE_BITS'((32'd1 << $urandom_range(0, SIZE_BITS - 1)) + $urandom_range(0, 3));
			default: return $urandom_range(1) ? '1 : '0;
		endcase
	endfunction

	function automatic logic [WIDE_BITS-1:0] rand_req();
		longint v;
		case ($urandom_range(9))
			0: return WIDE_BITS'($urandom);
			1, 2: return {1'b0, SIZE_BITS'($urandom)};
			3, 4: begin
				v = longint'(lim_min) + longint'($urandom_range(0, 2048)) - 1024;
				return v[WIDE_BITS-1:0];
			end
			5, 6: begin
				v = (longint'(1) << $urandom_range(0, SIZE_BITS)) + longint'($urandom_range(0, 64)) - 32;
				return v[WIDE_BITS-1:0];
			end
			default: return WIDE_BITS'($urandom_range(1, 4096));
		endcase
	endfunction

	task automatic rand_limits;
		logic [SIZE_BITS-1:0] lo, hi, tmp;
		logic [WIDE_BITS-1:0] step;
		lo = rand_size();
		hi = rand_size();
		if (hi < lo && $urandom_range(9) < 7) begin
			tmp = lo;
			lo  = hi;
			hi  = tmp;
		end
		case ($urandom_range(9))
			0, 1, 2, 3: step = POW_MODE;
			4, 5, 6, 7: step = $urandom_range(1) ? WIDE_BITS'($urandom_range(1, 300))
				: WIDE_BITS'($urandom_range(1, 1048575));
			8: begin
				hi   = lo;
				step = $urandom_range(1) ? POW_MODE : WIDE_BITS'($urandom_range(1, 500));
			end
			default: step = $urandom_range(1) ? '0 : {1'b1, SIZE_BITS'($urandom)};
		endcase
		set_limits({1'($urandom_range(1)), lo}, {1'($urandom_range(1)), hi},
			{1'($urandom_range(1)), rand_size()}, step);
	endtask

	initial begin
		arst_n         = 1'b0;
		start          = 1'b0;
		requested_size = '0;
		wr_en          = 1'b0;
		wr_index       = '0;
		wr_data        = '0;
		fix_valid      = 1'b0;
		fix_size       = '0;
		idle_pct       = 0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			if (rows[i].lo != lim_min || rows[i].hi != lim_max || rows[i].pref != lim_pref
					|| rows[i].step != lim_step) begin
				drain();
				set_limits({1'b0, rows[i].lo}, {1'b0, rows[i].hi}, {1'b0, rows[i].pref},
					rows[i].step);
			end
			send_item(rows[i].req, rows[i].typed, rows[i].size);
		end

		for (int p = 0; p < PHASES; p++) begin
			drain();
			case (p)
				0: set_limits(21'd1, 21'h0FFFFF, 21'h0FFFFF, POW_MODE);
				1: set_limits(21'd0, 21'h0FFFFF, 21'd0, 21'h0FFFFF);
				default: rand_limits();
			endcase
			idle_pct = idle_pcts[p % 3];
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(99) == 0)
					drain();
				send_item(rand_req(), 1'b0, '0);
			end
		end

		drain();
		repeat (LATENCY + 4) @(posedge clk);
		if (mismatches == 0 && chosen_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end
endmodule
